/* sv/mtrg_pkg.sv */
`timescale 1ns / 1ps

package mtrg_pkg;

	localparam int STATE_WORDS   = 624;
	localparam int MIDDLE_OFFSET = 397;
	localparam int WORD_BITS     = 32;
	localparam int INDEX_BITS    = $clog2(STATE_WORDS);

	localparam logic [WORD_BITS-1:0] TWIST_MATRIX  = 32'h9908_b0df;
	localparam logic [WORD_BITS-1:0] TEMPER_MASK_B = 32'h9d2c_5680;
	localparam logic [WORD_BITS-1:0] TEMPER_MASK_C = 32'hefc6_0000;
	localparam logic [WORD_BITS-1:0] SEED_MULT     = 32'd1812433253;
	localparam logic [WORD_BITS-1:0] HIGH_BIT      = 32'h8000_0000;
	localparam logic [WORD_BITS-1:0] LOW_BITS      = 32'h7fff_ffff;
	localparam logic [WORD_BITS-1:0] DEFAULT_SEED  = 32'd5489;

	localparam logic [INDEX_BITS-1:0] LAST_INDEX = INDEX_BITS'(STATE_WORDS - 1);

	localparam logic CMD_GENERATE = 1'b0;
	localparam logic CMD_RESEED   = 1'b1;

	typedef logic [WORD_BITS-1:0] word_t;

	// seeding sequencer towards the shift line
	typedef struct packed {
		logic  busy;
		logic  shift;
		word_t word;
	} mtrg_seed_ctl_t;

endpackage

/* sv/mtrg_cell.sv */
`timescale 1ns / 1ps

module mtrg_cell
	import mtrg_pkg::*;
(
	input  logic  clk,
	input  logic  shift,
	input  word_t d,
	output word_t q
);

	word_t word_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

/* sv/mtrg_seed_unit.sv */
`timescale 1ns / 1ps

module mtrg_seed_unit
	import mtrg_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  word_t          seed,
	input  word_t          tail,
	output mtrg_seed_ctl_t ctl
);

	logic                  busy_q;
	logic [INDEX_BITS-1:0] index_q;
	word_t                 seed_q;
	word_t                 mixed;
	word_t                 product;

	// x[k] = mult * (x[k-1] ^ (x[k-1] >> 30)) + k, previous word sits in the tail cell
	assign mixed   = tail ^ (tail >> 30);
	assign product = SEED_MULT * mixed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			index_q <= '0;
			seed_q  <= DEFAULT_SEED;
		end else if (start) begin
			busy_q  <= 1'b1;
			index_q <= '0;
			seed_q  <= seed;
		end else if (busy_q) begin
			index_q <= index_q + 1'b1;
			if (index_q == LAST_INDEX) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		ctl.busy  = busy_q;
		ctl.shift = busy_q;
		if (index_q == '0) begin
			ctl.word = seed_q;
		end else begin
			ctl.word = product + word_t'(index_q);
		end
	end

endmodule

/* sv/mtrg_twist_unit.sv */
`timescale 1ns / 1ps

module mtrg_twist_unit
	import mtrg_pkg::*;
(
	input  word_t head,
	input  word_t next,
	input  word_t middle,
	output word_t twisted,
	output word_t tempered
);

	word_t y;
	word_t t1;
	word_t t2;
	word_t t3;

	assign y       = (head & HIGH_BIT) | (next & LOW_BITS);
	assign twisted = middle ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);

	assign t1       = twisted ^ (twisted >> 11);
	assign t2       = t1 ^ ((t1 << 7) & TEMPER_MASK_B);
	assign t3       = t2 ^ ((t2 << 15) & TEMPER_MASK_C);
	assign tempered = t3 ^ (t3 >> 18);

endmodule

/* sv/mt19937_random_generator_core.sv */
`timescale 1ns / 1ps

// MT19937 generator built as a 624-word shift line of cells. In a generate transaction
// the feedback word is formed from the taps at cells 0, 1 and 397, shifted into the
// tail, and its tempered value is registered as the result, so generates stream
// at one word per cycle while the result is taken. A reseed transaction gives no
// result and runs the seeding recurrence one word per cycle through the seed
// multiplier over all 624 state words, during which cmd_ready is low. After reset
// the same pass runs with seed 5489 before the first transaction is accepted.
module mt19937_random_generator_core
	import mtrg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic        command,
	input  logic [31:0] seed_value,
	output logic        word_valid,
	input  logic        word_ready,
	output logic [31:0] random_word
);

	word_t          chain [STATE_WORDS+1];
	mtrg_seed_ctl_t seed_ctl;
	word_t          twisted;
	word_t          tempered;
	logic           shift;
	logic           gen_accept;
	logic           reseed_accept;
	logic           word_valid_q;
	word_t          random_word_q;

	assign cmd_ready     = !seed_ctl.busy && (!word_valid_q || word_ready);
	assign gen_accept    = cmd_valid && cmd_ready && (command == CMD_GENERATE);
	assign reseed_accept = cmd_valid && cmd_ready && (command == CMD_RESEED);
	assign shift         = seed_ctl.shift || gen_accept;
	assign chain[STATE_WORDS] = seed_ctl.busy ? seed_ctl.word : twisted;

	genvar i;
	generate
		for (i = 0; i < STATE_WORDS; i++) begin : g_cell
			mtrg_cell u_cell (
				.clk   (clk),
				.shift (shift),
				.d     (chain[i+1]),
				.q     (chain[i])
			);
		end
	endgenerate

	mtrg_seed_unit u_seed (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (reseed_accept),
		.seed   (seed_value),
		.tail   (chain[STATE_WORDS-1]),
		.ctl    (seed_ctl)
	);

	mtrg_twist_unit u_twist (
		.head     (chain[0]),
		.next     (chain[1]),
		.middle   (chain[MIDDLE_OFFSET]),
		.twisted  (twisted),
		.tempered (tempered)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_q <= 1'b0;
		end else if (gen_accept) begin
			word_valid_q <= 1'b1;
		end else if (word_ready) begin
			word_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_accept) begin
			random_word_q <= tempered;
		end
	end

	assign word_valid  = word_valid_q;
	assign random_word = random_word_q;

endmodule

/* sv/mtrg_checker.sv */
`timescale 1ns / 1ps

module mtrg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        command,
	input logic        word_valid,
	input logic        word_ready,
	input logic [31:0] random_word
);

	// a stalled result holds its word
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && !word_ready |=> word_valid && $stable(random_word))
		else $error("stalled result changed");

	// a reseed keeps the block busy in the following cycle
	a_reseed_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && command |=> !cmd_ready)
		else $error("transaction accepted straight after reseed");

	// a generate always leaves a result behind
	a_generate_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && !command |=> word_valid)
		else $error("generate gave no result");

	// no new transaction while the result register is full and stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && !word_ready |-> !cmd_ready)
		else $error("transaction accepted over a stalled result");

endmodule

bind mt19937_random_generator_core mtrg_checker u_mtrg_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
	import mtrg_pkg::*;

	localparam int DIRECTED_ROWS = 25;
	localparam int RANDOM_ITEMS  = 1600;
	localparam int STUCK_LIMIT   = 5000;
	localparam int DRAIN_CYCLES  = 10;

	typedef struct packed {
		logic  cmd;
		word_t seed;
		logic  typed;
		word_t want;
	} stim_row_t;

	logic  clk;
	logic  arst_n;
	logic  cmd_valid;
	logic  cmd_ready;
	logic  command;
	word_t seed_value;
	logic  word_valid;
	logic  word_ready;
	word_t random_word;

	// predictor copy of the generator
	word_t       mt_words[STATE_WORDS];
	int unsigned mt_index;

	word_t       pending_words[$];
	stim_row_t   dir_rows[DIRECTED_ROWS];
	int unsigned err_count;
	int unsigned stuck_cycles;
	int unsigned ready_stall;
	bit          calm;

	mt19937_random_generator_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.command     (command),
		.seed_value  (seed_value),
		.word_valid  (word_valid),
		.word_ready  (word_ready),
		.random_word (random_word)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void mt_seed(input word_t s);
		word_t prev;
		mt_words[0] = s;
		for (int k = 1; k < STATE_WORDS; k++) begin
			prev = mt_words[k-1];
			mt_words[k] = SEED_MULT * (prev ^ (prev >> 30)) + word_t'(k);
		end
		mt_index = STATE_WORDS;
	endfunction

	function automatic void mt_twist();
		word_t y;
		word_t v;
		for (int k = 0; k < STATE_WORDS; k++) begin
			y = (mt_words[k] & HIGH_BIT) | (mt_words[(k + 1) % STATE_WORDS] & LOW_BITS);
			v = mt_words[(k + MIDDLE_OFFSET) % STATE_WORDS] ^ (y >> 1);
			if (y[0]) begin
				v = v ^ TWIST_MATRIX;
			end
			mt_words[k] = v;
		end
		mt_index = 0;
	endfunction

	function automatic word_t mt_next();
		word_t y;
		if (mt_index >= STATE_WORDS) begin
			mt_twist();
		end
		y = mt_words[mt_index];
		mt_index++;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_MASK_B);
		y = y ^ ((y << 15) & TEMPER_MASK_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	// mostly short gaps, a few long ones, none at all during calm stretches
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task automatic send_cmd(input logic c, input word_t s, input logic typed, input word_t want);
		int unsigned gap;
		word_t       predicted;
		@(negedge clk);
		cmd_valid  <= 1'b1;
		command    <= c;
		seed_value <= s;
		do begin
			@(posedge clk);
		end while (!(cmd_valid && cmd_ready));
		if (c == CMD_RESEED) begin
			mt_seed(s);
		end else begin
			predicted = mt_next();
			pending_words.push_back(typed ? want : predicted);
		end
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain_words();
		while (pending_words.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// receiver: random stalls on word_ready
	initial begin
		word_ready  = 1'b0;
		ready_stall = 0;
		forever begin
			@(negedge clk);
			if (ready_stall > 0) begin
				word_ready <= 1'b0;
				ready_stall--;
			end else begin
				word_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) begin
					ready_stall = pick_gap();
				end
			end
		end
	end

	// result checking and watchdog
	always @(posedge clk) begin
		word_t want;
		if (arst_n) begin
			if (word_valid && word_ready) begin
				if (pending_words.size() == 0) begin
					$display("%0t: random_word %08h arrived with none expected", $time,
						random_word);
					err_count++;
				end else begin
					want = pending_words.pop_front();
					if (random_word !== want) begin
						$display("%0t: random_word mismatch, expected %08h, got %08h", $time,
							want, random_word);
						err_count++;
					end
				end
			end
			if ((cmd_valid && cmd_ready) || (word_valid && word_ready)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
			end
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	initial begin
		logic  c;
		word_t s;
		int unsigned r;

		arst_n       = 1'b0;
		cmd_valid    = 1'b0;
		command      = CMD_GENERATE;
		seed_value   = '0;
		err_count    = 0;
		stuck_cycles = 0;
		calm         = 1'b0;
		mt_seed(DEFAULT_SEED);

		// default sequence after reset, then seed extremes and a return to the default
		dir_rows[0]  = '{CMD_GENERATE, 32'h0000_0000, 1'b1, 32'd3499211612};
		dir_rows[1]  = '{CMD_GENERATE, 32'hffff_ffff, 1'b1, 32'd581869302};
		dir_rows[2]  = '{CMD_GENERATE, 32'h0000_0000, 1'b1, 32'd3890346734};
		dir_rows[3]  = '{CMD_GENERATE, 32'hffff_ffff, 1'b1, 32'd3586334585};
		dir_rows[4]  = '{CMD_GENERATE, 32'h0000_0000, 1'b1, 32'd545404204};
		dir_rows[5]  = '{CMD_RESEED,   32'h0000_0000, 1'b0, 32'h0};
		dir_rows[6]  = '{CMD_GENERATE, 32'h0000_0000, 1'b0, 32'h0};
		dir_rows[7]  = '{CMD_GENERATE, 32'hffff_ffff, 1'b0, 32'h0};
		dir_rows[8]  = '{CMD_RESEED,   32'hffff_ffff, 1'b0, 32'h0};
		dir_rows[9]  = '{CMD_GENERATE, 32'h0000_0000, 1'b0, 32'h0};
		dir_rows[10] = '{CMD_GENERATE, 32'h0000_0000, 1'b0, 32'h0};
		dir_rows[11] = '{CMD_RESEED,   DEFAULT_SEED,  1'b0, 32'h0};
		dir_rows[12] = '{CMD_GENERATE, 32'h0000_0000, 1'b1, 32'd3499211612};
		dir_rows[13] = '{CMD_GENERATE, 32'h0000_0000, 1'b1, 32'd581869302};
		dir_rows[14] = '{CMD_RESEED,   32'haaaa_aaaa, 1'b0, 32'h0};
		dir_rows[15] = '{CMD_GENERATE, 32'h5555_5555, 1'b0, 32'h0};
		dir_rows[16] = '{CMD_RESEED,   32'h5555_5555, 1'b0, 32'h0};
		dir_rows[17] = '{CMD_GENERATE, 32'haaaa_aaaa, 1'b0, 32'h0};
		dir_rows[18] = '{CMD_RESEED,   32'h0000_0001, 1'b0, 32'h0};
		dir_rows[19] = '{CMD_GENERATE, 32'h0000_0000, 1'b0, 32'h0};
		dir_rows[20] = '{CMD_RESEED,   32'h8000_0000, 1'b0, 32'h0};
		dir_rows[21] = '{CMD_GENERATE, 32'h0000_0000, 1'b0, 32'h0};
		// back-to-back reseeds, the second must win
		dir_rows[22] = '{CMD_RESEED,   32'h1234_5678, 1'b0, 32'h0};
		dir_rows[23] = '{CMD_RESEED,   DEFAULT_SEED,  1'b0, 32'h0};
		dir_rows[24] = '{CMD_GENERATE, 32'h0000_0000, 1'b1, 32'd3499211612};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			send_cmd(dir_rows[i].cmd, dir_rows[i].seed, dir_rows[i].typed, dir_rows[i].want);
		end

		// long generate runs cross the twist boundary, reseeds cluster in the middle
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 200 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
			end
			if (i == 400) begin
				@(negedge clk);
				cmd_valid <= 1'b0;
				drain_words();
			end
			c = CMD_GENERATE;
			if (i >= 700 && i < 900 && $urandom_range(0, 19) == 0) begin
				c = CMD_RESEED;
			end
			r = $urandom_range(0, 99);
			if (r < 5) begin
				s = '0;
			end else if (r < 10) begin
				s = '1;
			end else begin
				s = $urandom;
			end
			send_cmd(c, s, 1'b0, '0);
		end

		@(negedge clk);
		cmd_valid <= 1'b0;
		drain_words();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
